FILE: rtl/m4rm_pkg.sv
// Shared types and constants for the 4x4 row multiply block.
`timescale 1ns / 1ps

package m4rm_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int DIM       = 4;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHIFT_W   = SUM_W - FRAC_W;
  localparam int CFG_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int ROW_W     = DIM * ELEM_W;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DIM-1:0]          vec_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;

  // Right matrix resets to identity (Q16.16 one is 0x10000).
  localparam cfg_word_t [0:CFG_REGS-1] CFG_RESET = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  // One column's finished element.
  typedef struct packed {
    logic signed [ELEM_W-1:0] p;
    logic                     sat;
  } lane_res_t;

  // What the lanes hand to the merging stage.
  typedef struct packed {
    logic                 valid;
    lane_res_t [DIM-1:0]  lane;
  } res_bundle_t;

  // One result row as it sits in the output register or skid stage.
  typedef struct packed {
    logic             sat;
    logic [ROW_W-1:0] data;
  } out_item_t;

endpackage

FILE: rtl/m4rm_lane.sv
// One output column: four products, adder tree, shift and saturate.
`timescale 1ns / 1ps

module m4rm_lane (
  input  logic                clk,
  input  logic                en,
  input  m4rm_pkg::vec_t      a,
  input  m4rm_pkg::vec_t      b,
  output m4rm_pkg::lane_res_t res
);

  logic signed [m4rm_pkg::PROD_W-1:0]  prod_r [m4rm_pkg::DIM];
  logic signed [m4rm_pkg::PROD_W-1:0]  prod_nxt [m4rm_pkg::DIM];
  logic signed [m4rm_pkg::PAIR_W-1:0]  pair_r [2];
  logic signed [m4rm_pkg::PAIR_W-1:0]  pair_nxt [2];
  logic signed [m4rm_pkg::SUM_W-1:0]   sum;
  logic signed [m4rm_pkg::SHIFT_W-1:0] shifted;
  logic [m4rm_pkg::SHIFT_W-m4rm_pkg::ELEM_W:0] upper;
  m4rm_pkg::lane_res_t res_r, res_nxt;

  always_comb begin
    for (int k = 0; k < m4rm_pkg::DIM; k++) begin
      prod_nxt[k] = $signed(a[k]) * $signed(b[k]);
    end
    pair_nxt[0] = m4rm_pkg::PAIR_W'(prod_r[0]) + m4rm_pkg::PAIR_W'(prod_r[1]);
    pair_nxt[1] = m4rm_pkg::PAIR_W'(prod_r[2]) + m4rm_pkg::PAIR_W'(prod_r[3]);
  end

  // Exact sum, floor by arithmetic shift, then clip to 32 bits.
  always_comb begin
    sum     = m4rm_pkg::SUM_W'(pair_r[0]) + m4rm_pkg::SUM_W'(pair_r[1]);
    shifted = m4rm_pkg::SHIFT_W'(sum >>> m4rm_pkg::FRAC_W);
    upper   = shifted[m4rm_pkg::SHIFT_W-1:m4rm_pkg::ELEM_W-1];
    if ((&upper) || !(|upper)) begin
      res_nxt.p   = shifted[m4rm_pkg::ELEM_W-1:0];
      res_nxt.sat = 1'b0;
    end else begin
      res_nxt.p   = shifted[m4rm_pkg::SHIFT_W-1] ? {1'b1, {(m4rm_pkg::ELEM_W-1){1'b0}}}
                                                 : {1'b0, {(m4rm_pkg::ELEM_W-1){1'b1}}};
      res_nxt.sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      pair_r <= pair_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/m4rm_merge.sv
// Merging stage: join lane results, output register and skid stage.
`timescale 1ns / 1ps

module m4rm_merge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  m4rm_pkg::res_bundle_t     res_in,
  output logic                      ready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [m4rm_pkg::ROW_W-1:0] out_tdata,  // p_col0, p_col1, p_col2, p_col3
  output logic                      out_tuser   // saturated
);

  logic                ov_r, ov_nxt, sv_r, sv_nxt, pop;
  m4rm_pkg::out_item_t od_r, od_nxt, sd_r, sd_nxt, item;

  always_comb begin
    item.sat = 1'b0;
    for (int j = 0; j < m4rm_pkg::DIM; j++) begin
      item.data[j*m4rm_pkg::ELEM_W +: m4rm_pkg::ELEM_W] = res_in.lane[j].p;
      item.sat = item.sat | res_in.lane[j].sat;
    end
  end

  assign pop   = ov_r && out_tready;
  assign ready = !sv_r;

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    sv_nxt = sv_r;
    sd_nxt = sd_r;
    if (!ov_r || pop) begin
      if (sv_r) begin
        // drain the skid stage first to keep order
        ov_nxt = 1'b1;
        od_nxt = sd_r;
        sv_nxt = 1'b0;
      end else begin
        ov_nxt = res_in.valid;
        if (res_in.valid) begin
          od_nxt = item;
        end
      end
    end else if (res_in.valid) begin
      sv_nxt = 1'b1;
      sd_nxt = item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r.data;
  assign out_tuser  = od_r.sat;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid stage holds a row while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sv_r) |-> $past(ov_r && !out_tready))
    else $error("skid stage filled without a stalled output");

  a_stalled_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready && !sv_r && res_in.valid) |=> sv_r)
    else $error("row arriving during a stall was not captured");

endmodule

FILE: rtl/matrix4_row_multiply_unit.sv
// Top level of the 4x4 fixed-point row multiply block.
`timescale 1ns / 1ps

// Row-by-matrix multiply, Q16.16. Each input transaction on in_* carries one
// row of the left matrix; each output transaction on out_* carries the product
// row and a flag that is set when any element was clipped to 32 bits.
// The right matrix lives in eight 64-bit registers written through cfg_*;
// register i is written at any edge with cfg_wr_en high. Write them only
// while no row is in flight. Reset loads the identity matrix.
// Four column lanes run in parallel, each with four 32x32 multipliers, a
// two-level adder tree and a shift/saturate step; a merging stage joins the
// lanes and ORs the saturation flags.
// A row accepted on in_* passes the input register, product, pair sum, final
// sum and output register before it is presented on out_*.
// Throughput: one row per clock while the skid stage is free. in_tready comes
// from a register: it drops at the same edge at which the skid stage behind
// the output register fills, which happens only while the receiver holds
// out_tready low with a row waiting. The whole pipeline then holds until the
// receiver takes a row. Reset (synchronous, active low) empties the pipeline
// and output stage.
module matrix4_row_multiply_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [m4rm_pkg::ROW_W-1:0]     in_tdata,   // a_col0, a_col1, a_col2, a_col3
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [m4rm_pkg::ROW_W-1:0]     out_tdata,  // p_col0, p_col1, p_col2, p_col3
  output logic                           out_tuser,  // saturated
  input  logic                           cfg_wr_en,
  input  logic [m4rm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [m4rm_pkg::CFG_W-1:0]     cfg_wdata
);

  m4rm_pkg::cfg_word_t   cfg_r [m4rm_pkg::CFG_REGS];
  m4rm_pkg::vec_t        a0_r;
  m4rm_pkg::vec_t        b_col [m4rm_pkg::DIM];
  logic                  v0_r, v1_r, v2_r, v3_r;
  logic                  pipe_adv;
  m4rm_pkg::res_bundle_t bundle;

  // Configuration registers: plain write, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < m4rm_pkg::CFG_REGS; i++) begin
        cfg_r[i] <= m4rm_pkg::CFG_RESET[i];
      end
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // Column j of B: row k sits in register 2k + j/2, high half for odd j.
  always_comb begin
    for (int j = 0; j < m4rm_pkg::DIM; j++) begin
      for (int k = 0; k < m4rm_pkg::DIM; k++) begin
        if ((j % 2) == 1) begin
          b_col[j][k] = cfg_r[m4rm_pkg::CFG_IDX_W'(2 * k + j / 2)][m4rm_pkg::CFG_W-1:
                                                                   m4rm_pkg::ELEM_W];
        end else begin
          b_col[j][k] = cfg_r[m4rm_pkg::CFG_IDX_W'(2 * k + j / 2)][m4rm_pkg::ELEM_W-1:0];
        end
      end
    end
  end

  // Advance every stage together whenever the skid stage is free.
  assign in_tready = pipe_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (pipe_adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (pipe_adv) begin
      a0_r <= in_tdata;
    end
  end

  for (genvar j = 0; j < m4rm_pkg::DIM; j++) begin : g_lane
    m4rm_lane u_lane (
      .clk (clk),
      .en  (pipe_adv),
      .a   (a0_r),
      .b   (b_col[j]),
      .res (bundle.lane[j])
    );
  end

  // Hand the finished row over only on an advancing cycle.
  assign bundle.valid = v3_r && pipe_adv;

  m4rm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_in     (bundle),
    .ready      (pipe_adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: tb/sv/m4rm_checker.sv
// Checker for the 4x4 row multiply block: predicts each product row and compares it.
`timescale 1ns / 1ps

module m4rm_checker
  import m4rm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [ROW_W-1:0]     in_tdata,   // a_col0, a_col1, a_col2, a_col3
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [ROW_W-1:0]     out_tdata,  // p_col0, p_col1, p_col2, p_col3
  input  logic                 out_tuser,  // saturated
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   rows_pending,
  output int                   rows_checked,
  output int                   clipped_rows
);

  typedef struct packed {
    logic sat;
    vec_t cols;
  } product_row_t;

  // Four 64-bit products summed need 66 bits; keep some headroom.
  localparam int                        ACC_W   = 68;
  localparam logic signed [ACC_W-1:0]   ELEM_HI = 68'sh0_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0]   ELEM_LO = -68'sh0_8000_0000;
  localparam elem_t                     Q_ONE   = 32'sh0001_0000;

  elem_t        right_mat [DIM][DIM];
  product_row_t expected_rows [$];
  int           fails     = 0;
  int           checked   = 0;
  int           clipped   = 0;
  int           pending_q = 0;

  assign fail_count   = fails;
  assign rows_pending = pending_q;
  assign rows_checked = checked;
  assign clipped_rows = clipped;

  // Exact dot product per column, floor shift by 16, clip to 32 bits.
  function automatic product_row_t product_of(input vec_t a_row);
    product_row_t            res;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] wide_a;
    logic signed [ACC_W-1:0] wide_b;
    logic signed [ACC_W-1:0] scaled;
    int                      j;
    int                      k;
    res.sat = 1'b0;
    for (j = 0; j < DIM; j++) begin
      acc = '0;
      for (k = 0; k < DIM; k++) begin
        wide_a = signed'(a_row[k]);
        wide_b = signed'(right_mat[k][j]);
        acc    = acc + wide_a * wide_b;
      end
      scaled = acc >>> FRAC_W;
      if (scaled > ELEM_HI) begin
        res.cols[j] = ELEM_HI[ELEM_W-1:0];
        res.sat     = 1'b1;
      end else if (scaled < ELEM_LO) begin
        res.cols[j] = ELEM_LO[ELEM_W-1:0];
        res.sat     = 1'b1;
      end else begin
        res.cols[j] = scaled[ELEM_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    product_row_t seen;
    product_row_t want;
    int           j;
    int           k;
    int           pair;
    if (!rst_n) begin
      for (k = 0; k < DIM; k++) begin
        for (j = 0; j < DIM; j++) begin
          right_mat[k][j] = (k == j) ? Q_ONE : '0;
        end
      end
      expected_rows.delete();
      pending_q <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.cols = out_tdata;
        seen.sat  = out_tuser;
        if (expected_rows.size() == 0) begin
          fails++;
          $display("%0t: product row with none expected: data %h sat %b",
                   $time, seen.cols, seen.sat);
        end else begin
          want = expected_rows.pop_front();
          for (j = 0; j < DIM; j++) begin
            if (seen.cols[j] !== want.cols[j]) begin
              fails++;
              $display("%0t: row %0d p_col%0d expected %h actual %h",
                       $time, checked, j, want.cols[j], seen.cols[j]);
            end
          end
          if (seen.sat !== want.sat) begin
            fails++;
            $display("%0t: row %0d saturated expected %b actual %b",
                     $time, checked, want.sat, seen.sat);
          end
          checked++;
          if (want.sat) begin
            clipped++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_rows.push_back(product_of(in_tdata));
      end
      // Register 2k+p holds row k, columns 2p (low half) and 2p+1 (high half).
      if (cfg_wr_en) begin
        k    = int'(cfg_index) / 2;
        pair = int'(cfg_index) % 2;
        right_mat[k][2*pair]     = cfg_wdata[ELEM_W-1:0];
        right_mat[k][2*pair + 1] = cfg_wdata[CFG_W-1:ELEM_W];
      end
      pending_q <= expected_rows.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the testbench for the 4x4 row multiply block: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import m4rm_pkg::*;

  // Names of the eight right-matrix registers, in index order.
  typedef enum int {
    B_R0_C01, B_R0_C23, B_R1_C01, B_R1_C23,
    B_R2_C01, B_R2_C23, B_R3_C01, B_R3_C23
  } b_reg_e;

  // How wide the random operands spread.
  typedef enum int {SPAN_NARROW, SPAN_MIXED, SPAN_WIDE} span_e;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_ROWS   = 200;
  localparam int RANDOM_PHASES = 5;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [ROW_W-1:0]     in_tdata   = '0;   // a_col0, a_col1, a_col2, a_col3
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [ROW_W-1:0]     out_tdata;         // p_col0, p_col1, p_col2, p_col3
  logic                 out_tuser;         // saturated
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  int   fail_count;
  int   rows_pending;
  int   rows_checked;
  int   clipped_rows;
  int   cycle_count  = 0;
  int   settings     = 0;

  // Sender and receiver idling switches; the receiver's is read in another
  // process, so change it with nonblocking assignments only.
  bit   tx_gaps_on   = 1'b1;
  logic rx_stalls_on = 1'b1;

  // Hold-off handshake between stimulus and receiver: bump hold_asked to
  // request one long stall; the receiver counts it down on its own.
  int   hold_asked   = 0;
  int   hold_granted = 0;
  int   hold_left    = 0;

  always #1 clk = ~clk;

  matrix4_row_multiply_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  m4rm_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked),
    .clipped_rows (clipped_rows)
  );

  // Receiver: stall at random with odds of about 38 in 100, hold off for a long
  // stretch when asked, and never stall at random while stalls are switched off.
  always @(posedge clk) begin
    if (hold_granted != hold_asked) begin
      hold_granted = hold_asked;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!rx_stalls_on) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 38);
    end
  end

  // Watchdog: a hung handshake or a lost row ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d rows outstanding",
               cycle_count, rows_pending);
      $display("FAIL matrix4_row_multiply_unit");
      $finish;
    end
  end

  // Random Q16.16 element: corners now and then, otherwise values near zero
  // (about +-4.0) or full 32-bit patterns depending on the span.
  function automatic elem_t rand_elem(input span_e span);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(6))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        4:       return 32'h0001_0000;
        5:       return 32'hFFFF_0000;
        default: return 32'h0000_0001;
      endcase
    end
    if (span == SPAN_NARROW || (span == SPAN_MIXED && pick < 55)) begin
      return elem_t'($urandom_range(32'h7_FFFF) - 32'h4_0000);
    end
    return elem_t'($urandom);
  endfunction

  // Offer one row and hold it until the block takes it; then maybe idle.
  task automatic send_row(input elem_t c0, input elem_t c1, input elem_t c2, input elem_t c3);
    in_tvalid <= 1'b1;
    in_tdata  <= {c3, c2, c1, c0};
    do @(posedge clk); while (!in_tready);
    if (tx_gaps_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted row has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
  endtask

  task automatic write_reg(input int idx, input cfg_word_t word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= word;
    @(posedge clk);
  endtask

  // Fill every element of the right matrix with the same value.
  task automatic load_uniform(input elem_t v);
    int r;
    for (r = B_R0_C01; r <= B_R3_C23; r++) begin
      write_reg(r, {v, v});
    end
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  task automatic load_random(input span_e span);
    int r;
    for (r = B_R0_C01; r <= B_R3_C23; r++) begin
      write_reg(r, {rand_elem(span), rand_elem(span)});
    end
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    int    ph;
    int    n;
    span_e span;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings = 1;

    // Identity after reset: every row must come back unchanged, corners included.
    send_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_row(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_row(32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'hFFFD_8000);
    send_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_for_drain();

    // Most negative matrix: min*min overflows high, max*min overflows low,
    // a single unit element shows the exact floor of a negative sum.
    load_uniform(32'h8000_0000);
    send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_row(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    wait_for_drain();

    // Most positive matrix: clip both ways, and a one that lands exactly on max.
    load_uniform(32'h7FFF_FFFF);
    send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_row(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    wait_for_drain();

    // Matrix of -1 LSB: tiny negative sums must round down to -1, not to 0.
    load_uniform(32'hFFFF_FFFF);
    send_row(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_row(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    wait_for_drain();

    // Zero matrix.
    load_uniform(32'h0000_0000);
    send_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_for_drain();

    // Random phases, each with its own right matrix. Phase 0 runs with no
    // idling on either side; phase 2 starts with a long output hold-off while
    // rows keep coming, so the pipeline fills and stalls its input.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0, 1, 2: span = SPAN_NARROW;
        3:       span = SPAN_MIXED;
        default: span = SPAN_WIDE;
      endcase
      load_random(span);
      tx_gaps_on   = (ph != 0);
      rx_stalls_on <= (ph != 0);
      if (ph == 2) begin
        hold_asked <= hold_asked + 1;
        tx_gaps_on = 1'b0;
      end
      for (n = 0; n < PHASE_ROWS; n++) begin
        if (ph == 2 && n == 60) begin
          tx_gaps_on = 1'b1;
        end
        send_row(rand_elem(span), rand_elem(span), rand_elem(span), rand_elem(span));
      end
      wait_for_drain();
    end

    // Let any stray row surface before the verdict.
    repeat (8) @(posedge clk);

    $display("Checked %0d product rows over %0d right-matrix settings; %0d were clipped.",
             rows_checked, settings, clipped_rows);
    $display("Covered operand corners, floor of negative sums, and a long output hold-off.");
    if (fail_count == 0) begin
      $display("PASS matrix4_row_multiply_unit");
    end else begin
      $display("FAIL matrix4_row_multiply_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/m4rm_pkg.sv
rtl/m4rm_lane.sv
rtl/m4rm_merge.sv
rtl/matrix4_row_multiply_unit.sv
tb/sv/m4rm_checker.sv
tb/sv/tb_top.sv
